### src/pam_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the plane association matcher
// used by every module of the block, but not by the channel interfaces

package pam_pkg;

    localparam logic [1:0] MODE_OBS = 2'd0;
    localparam logic [1:0] MODE_HDR = 2'd1;
    localparam logic [1:0] MODE_PT  = 2'd2;
    localparam logic [1:0] MODE_END = 2'd3;

    localparam int unsigned MAP_PLANES = 1024;

    localparam logic [15:0] DIST_LIMIT = 16'd25600;
    localparam logic [15:0] COS_SAT    = 16'hFFFF;
    localparam logic [14:0] PAR_MAX    = 15'h7FFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] REG_DIST  = 2'd0;
    localparam logic [1:0] REG_ASSOC = 2'd1;
    localparam logic [1:0] REG_VERT  = 2'd2;
    localparam logic [1:0] REG_PAR   = 2'd3;

    typedef struct packed {
        logic [15:0] dist_thr;
        logic [14:0] assoc_thr;
        logic [14:0] vert_thr;
        logic [14:0] par_thr;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic               first;
        logic signed [23:0] vec_x;
        logic signed [23:0] vec_y;
        logic signed [23:0] vec_z;
        logic signed [23:0] offset;
        logic [9:0]         index;
        logic               bad;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       first;
        logic [9:0] index;
        logic       bad;
    } t_tag;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### src/pam_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for items in and results out
// depends on nothing but plain logic types

interface pam_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic               first_of_frame;
    logic signed [23:0] vec_x;
    logic signed [23:0] vec_y;
    logic signed [23:0] vec_z;
    logic signed [23:0] plane_offset;
    logic [9:0]         map_index;
    logic               map_bad;

    modport source (output valid, mode, first_of_frame, vec_x, vec_y, vec_z,
                    plane_offset, map_index, map_bad, input ready);
    modport sink (input valid, mode, first_of_frame, vec_x, vec_y, vec_z,
                  plane_offset, map_index, map_bad, output ready);
endinterface

interface pam_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [9:0] match_index;
    logic       vertical_found;
    logic [9:0] vertical_index;
    logic       parallel_found;
    logic [9:0] parallel_index;
    logic [6:0] match_count;

    modport source (output valid, matched, match_index, vertical_found,
                    vertical_index, parallel_found, parallel_index, match_count,
                    input ready);
    modport sink (input valid, matched, match_index, vertical_found,
                  vertical_index, parallel_found, parallel_index, match_count,
                  output ready);
endinterface

### src/pam_front.sv
`timescale 1ns / 1ps
// front end: classifies an incoming transfer into a queue entry
// saturates normals and flags bad map planes; uses pam_pkg and pam_in_if

module pam_front (
    pam_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output pam_pkg::t_item o_item
);

    logic normal_mode;
    logic out_of_range;

    assign normal_mode  = (i_in.mode == pam_pkg::MODE_OBS) || (i_in.mode == pam_pkg::MODE_HDR);
    assign out_of_range = 32'(i_in.map_index) >= pam_pkg::MAP_PLANES;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.mode   = i_in.mode;
        o_item.first  = i_in.first_of_frame;
        o_item.offset = i_in.plane_offset;
        o_item.index  = i_in.map_index;
        o_item.bad    = i_in.map_bad || out_of_range;
        if (normal_mode) begin
            o_item.vec_x = 24'(pam_pkg::sat16(i_in.vec_x));
            o_item.vec_y = 24'(pam_pkg::sat16(i_in.vec_y));
            o_item.vec_z = 24'(pam_pkg::sat16(i_in.vec_z));
        end else begin
            o_item.vec_x = i_in.vec_x;
            o_item.vec_y = i_in.vec_y;
            o_item.vec_z = i_in.vec_z;
        end
    end

endmodule

### src/pam_queue.sv
`timescale 1ns / 1ps
// short queue between front end and back end
// holds classified entries of type pam_pkg::t_item

module pam_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pam_pkg::t_item i_item,
    input  logic           i_pop,
    output pam_pkg::t_item o_head,
    output logic           o_nonempty,
    output logic           o_full
);

    pam_pkg::t_item r_mem [pam_pkg::QDEPTH];
    logic [pam_pkg::QPTR_W-1:0] r_wr;
    logic [pam_pkg::QPTR_W-1:0] r_rd;
    logic [pam_pkg::QPTR_W:0]   r_cnt;
    logic do_pop;

    assign o_head     = r_mem[r_rd];
    assign o_nonempty = r_cnt != '0;
    assign o_full     = r_cnt == (pam_pkg::QPTR_W+1)'(pam_pkg::QDEPTH);
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/pam_back.sv
`timescale 1ns / 1ps
// back end: dot products, magnitude, running minimum and plane decisions
// three pipeline stages then commit; uses pam_pkg and pam_out_if

module pam_back #(
    parameter int FRAME_PLANES = 64,
    parameter int MW           = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pam_pkg::t_cfg  i_cfg,
    input  pam_pkg::t_item i_head,
    input  logic           i_nonempty,
    output logic           o_pop,
    pam_out_if.source      o_out
);

    logic adv;

    logic signed [15:0] r_obs_x, r_obs_y, r_obs_z;
    logic signed [23:0] r_obs_off;

    logic               r1_v;
    pam_pkg::t_tag      r1_tag;
    logic signed [39:0] r1_p0, r1_p1, r1_p2;
    logic signed [37:0] r1_off;

    logic               r2_v;
    pam_pkg::t_tag      r2_tag;
    logic signed [41:0] r2_sum;

    logic               r3_v;
    pam_pkg::t_tag      r3_tag;
    logic [15:0]        r3_val;

    logic signed [39:0] p0, p1, p2;
    logic signed [41:0] sum;
    logic [41:0]        mag;
    logic [27:0]        shifted;
    logic [15:0]        val;

    logic [15:0] r_best_dist, n_best_dist;
    logic [14:0] r_best_vert, n_best_vert;
    logic [14:0] r_best_par, n_best_par;
    logic [15:0] r_pend_cos, n_pend_cos;
    logic [9:0]  r_pend_idx, n_pend_idx;
    logic        r_pend_v, n_pend_v;
    logic        r_pend_bad, n_pend_bad;
    logic [15:0] r_min, n_min;
    logic [9:0]  r_pick_m, n_pick_m;
    logic [9:0]  r_pick_v, n_pick_v;
    logic [9:0]  r_pick_p, n_pick_p;
    logic [2:0]  r_flags, n_flags;
    logic [MW-1:0] r_matches, n_matches;
    logic          commit;
    logic          emit;

    assign adv   = !(r3_v && (r3_tag.mode == pam_pkg::MODE_END) && o_out.valid && !o_out.ready);
    assign o_pop = adv && i_nonempty;

    assign p0 = r_obs_x * i_head.vec_x;
    assign p1 = r_obs_y * i_head.vec_y;
    assign p2 = r_obs_z * i_head.vec_z;

    // stage 1: products, observed plane loads here so the next item sees it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_x   <= '0;
            r_obs_y   <= '0;
            r_obs_z   <= '0;
            r_obs_off <= '0;
        end else if (o_pop && (i_head.mode == pam_pkg::MODE_OBS)) begin
            r_obs_x   <= i_head.vec_x[15:0];
            r_obs_y   <= i_head.vec_y[15:0];
            r_obs_z   <= i_head.vec_z[15:0];
            r_obs_off <= i_head.offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_tag <= '{mode: i_head.mode, first: i_head.first,
                        index: i_head.index, bad: i_head.bad};
            r1_p0  <= p0;
            r1_p1  <= p1;
            r1_p2  <= p2;
            if (i_head.mode == pam_pkg::MODE_PT) begin
                r1_off <= {r_obs_off, 14'b0};
            end else begin
                r1_off <= '0;
            end
            r2_tag <= r1_tag;
            r2_sum <= sum;
            r3_tag <= r2_tag;
            r3_val <= val;
        end
    end

    // stage 2: sum of terms
    assign sum = 42'(r1_p0) + 42'(r1_p1) + 42'(r1_p2) + 42'(r1_off);

    // stage 3: magnitude, shift and saturate
    assign mag     = r2_sum[41] ? 42'(-r2_sum) : 42'(r2_sum);
    assign shifted = mag[41:14];

    always_comb begin
        if (r2_tag.mode == pam_pkg::MODE_PT) begin
            val = (shifted > 28'(pam_pkg::DIST_LIMIT)) ? pam_pkg::DIST_LIMIT : shifted[15:0];
        end else begin
            val = (shifted > 28'(pam_pkg::COS_SAT)) ? pam_pkg::COS_SAT : shifted[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (adv) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // commit
    assign commit = adv && r3_v;
    assign emit   = commit && (r3_tag.mode == pam_pkg::MODE_END);

    always_comb begin
        n_best_dist = r_best_dist;
        n_best_vert = r_best_vert;
        n_best_par  = r_best_par;
        n_pend_cos  = r_pend_cos;
        n_pend_idx  = r_pend_idx;
        n_pend_v    = r_pend_v;
        n_pend_bad  = r_pend_bad;
        n_min       = r_min;
        n_pick_m    = r_pick_m;
        n_pick_v    = r_pick_v;
        n_pick_p    = r_pick_p;
        n_flags     = r_flags;
        n_matches   = r_matches;
        case (r3_tag.mode)
            pam_pkg::MODE_OBS: begin
                if (r3_tag.first) begin
                    n_matches = '0;
                end
                n_best_dist = i_cfg.dist_thr;
                n_best_vert = i_cfg.vert_thr;
                n_best_par  = i_cfg.par_thr;
                n_pick_m    = '0;
                n_pick_v    = '0;
                n_pick_p    = '0;
                n_flags     = '0;
                n_pend_v    = 1'b0;
                n_pend_bad  = 1'b0;
                n_pend_cos  = '0;
                n_pend_idx  = '0;
                n_min       = pam_pkg::DIST_LIMIT;
            end
            pam_pkg::MODE_PT: begin
                if (r_pend_v && !r_pend_bad && (r3_val < r_min)) begin
                    n_min = r3_val;
                end
            end
            pam_pkg::MODE_HDR, pam_pkg::MODE_END: begin
                if (r_pend_v && !r_pend_bad) begin
                    if ((r_pend_cos > {1'b0, i_cfg.assoc_thr}) && (r_min < r_best_dist)) begin
                        n_best_dist = r_min;
                        n_pick_m    = r_pend_idx;
                        n_flags[0]  = 1'b1;
                    end else if (r_pend_cos < {1'b0, r_best_vert}) begin
                        n_best_vert = r_pend_cos[14:0];
                        n_pick_v    = r_pend_idx;
                        n_flags[1]  = 1'b1;
                    end else if (r_pend_cos > {1'b0, r_best_par}) begin
                        n_best_par  = r_pend_cos[15] ? pam_pkg::PAR_MAX : r_pend_cos[14:0];
                        n_pick_p    = r_pend_idx;
                        n_flags[2]  = 1'b1;
                    end
                end
                n_pend_v   = 1'b0;
                n_pend_bad = 1'b0;
                n_min      = pam_pkg::DIST_LIMIT;
                if (r3_tag.mode == pam_pkg::MODE_HDR) begin
                    n_pend_cos = r3_val;
                    n_pend_idx = r3_tag.index;
                    n_pend_v   = 1'b1;
                    n_pend_bad = r3_tag.bad;
                end else if (n_flags[0] && (r_matches < MW'(FRAME_PLANES))) begin
                    n_matches = MW'(r_matches + 1'b1);
                end
            end
            default: begin
                n_min = r_min;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= '0;
            r_best_vert <= '0;
            r_best_par  <= '0;
            r_pend_cos  <= '0;
            r_pend_idx  <= '0;
            r_pend_v    <= 1'b0;
            r_pend_bad  <= 1'b0;
            r_min       <= pam_pkg::DIST_LIMIT;
            r_pick_m    <= '0;
            r_pick_v    <= '0;
            r_pick_p    <= '0;
            r_flags     <= '0;
            r_matches   <= '0;
        end else if (commit) begin
            r_best_dist <= n_best_dist;
            r_best_vert <= n_best_vert;
            r_best_par  <= n_best_par;
            r_pend_cos  <= n_pend_cos;
            r_pend_idx  <= n_pend_idx;
            r_pend_v    <= n_pend_v;
            r_pend_bad  <= n_pend_bad;
            r_min       <= n_min;
            r_pick_m    <= n_pick_m;
            r_pick_v    <= n_pick_v;
            r_pick_p    <= n_pick_p;
            r_flags     <= emit ? 3'b000 : n_flags;
            r_matches   <= n_matches;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (emit) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_out.matched        <= n_flags[0];
            o_out.match_index    <= n_flags[0] ? n_pick_m : 10'd0;
            o_out.vertical_found <= n_flags[1];
            o_out.vertical_index <= n_flags[1] ? n_pick_v : 10'd0;
            o_out.parallel_found <= n_flags[2];
            o_out.parallel_index <= n_flags[2] ? n_pick_p : 10'd0;
            o_out.match_count    <= 7'(n_matches);
        end
    end

endmodule

### src/plane_association_matcher.sv
`timescale 1ns / 1ps
// top level: one observed plane against a stream of map planes
// result path: an end item passes the queue and the back-end pipeline, then its result is registered at commit
// throughput: one item per cycle while no result waits on a stalled output; the multiplier
// stage and the commit stage each take one item a cycle, a 4-entry queue decouples front and back
// reset: synchronous, active low; config returns to defaults, state clears, no sweep

module plane_association_matcher #(
    parameter int FRAME_PLANES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pam_in_if.sink      i_in_ch,
    pam_out_if.source   o_out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MW = $clog2(FRAME_PLANES + 1);

    pam_pkg::t_cfg  r_cfg;
    pam_pkg::t_item item;
    pam_pkg::t_item head;
    logic push, pop, nonempty, full;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dist_thr  <= 16'd20;
            r_cfg.assoc_thr <= 15'd14090;
            r_cfg.vert_thr  <= 15'd1311;
            r_cfg.par_thr   <= 15'd14746;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pam_pkg::REG_DIST:  r_cfg.dist_thr  <= pwdata[15:0];
                pam_pkg::REG_ASSOC: r_cfg.assoc_thr <= pwdata[14:0];
                pam_pkg::REG_VERT:  r_cfg.vert_thr  <= pwdata[14:0];
                pam_pkg::REG_PAR:   r_cfg.par_thr   <= pwdata[14:0];
                default:            r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pam_pkg::REG_DIST:  prdata = 32'(r_cfg.dist_thr);
            pam_pkg::REG_ASSOC: prdata = 32'(r_cfg.assoc_thr);
            pam_pkg::REG_VERT:  prdata = 32'(r_cfg.vert_thr);
            pam_pkg::REG_PAR:   prdata = 32'(r_cfg.par_thr);
            default:            prdata = '0;
        endcase
    end

    pam_front u_front (
        .i_in   (i_in_ch),
        .i_full (full),
        .o_push (push),
        .o_item (item)
    );

    pam_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_full     (full)
    );

    pam_back #(
        .FRAME_PLANES (FRAME_PLANES),
        .MW           (MW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (head),
        .i_nonempty (nonempty),
        .o_pop      (pop),
        .o_out      (o_out_ch)
    );

endmodule

### verif/tb_plane_association_matcher.sv
`timescale 1ns / 1ps
// self-checking testbench for plane_association_matcher: directed and random frames
// depends on pam_pkg, pam_in_if / pam_out_if and the block's top level

localparam int          MATCH_CAP = 64;
localparam logic [15:0] NEAR_CAP  = 16'd25600;

typedef struct packed {
    logic       matched;
    logic [9:0] match_index;
    logic       vertical_found;
    logic [9:0] vertical_index;
    logic       parallel_found;
    logic [9:0] parallel_index;
    logic [6:0] match_count;
} t_assoc_result;

class match_scoreboard;
    logic [15:0]        dist_thr;
    logic [14:0]        assoc_thr;
    logic [14:0]        vert_thr;
    logic [14:0]        par_thr;
    logic signed [15:0] obs_n [3];
    logic signed [23:0] obs_d;
    logic [15:0]        best_dist;
    logic [14:0]        best_vert;
    logic [14:0]        best_par;
    logic [15:0]        cand_cos;
    logic [9:0]         cand_index;
    logic               cand_live;
    logic               cand_skip;
    logic [15:0]        near_dist;
    logic [9:0]         pick_idx [3];
    logic [2:0]         pick_seen;
    logic [6:0]         frame_matches;
    t_assoc_result      expected_picks [$];
    int                 errors;
    int                 results_seen;
    int                 n_match;
    int                 n_vert;
    int                 n_par;

    function new();
        dist_thr = 16'd20;
        assoc_thr = 15'd14090;
        vert_thr = 15'd1311;
        par_thr = 15'd14746;
        foreach (obs_n[k]) obs_n[k] = '0;
        foreach (pick_idx[k]) pick_idx[k] = '0;
        obs_d = '0;
        best_dist = '0;
        best_vert = '0;
        best_par = '0;
        cand_cos = '0;
        cand_index = '0;
        cand_live = 1'b0;
        cand_skip = 1'b0;
        near_dist = NEAR_CAP;
        pick_seen = '0;
        frame_matches = '0;
        errors = 0;
        results_seen = 0;
        n_match = 0;
        n_vert = 0;
        n_par = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            pam_pkg::REG_DIST:  dist_thr = val[15:0];
            pam_pkg::REG_ASSOC: assoc_thr = val[14:0];
            pam_pkg::REG_VERT:  vert_thr = val[14:0];
            pam_pkg::REG_PAR:   par_thr = val[14:0];
        endcase
    endfunction

    function logic signed [15:0] to_q14(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // |n_obs . n_map| in Q2.14, magnitude truncated
    function logic [15:0] normal_cos(logic signed [23:0] mx, logic signed [23:0] my,
                                     logic signed [23:0] mz);
        longint dot;
        longint mag;
        dot = longint'(obs_n[0]) * longint'(to_q14(mx))
            + longint'(obs_n[1]) * longint'(to_q14(my))
            + longint'(obs_n[2]) * longint'(to_q14(mz));
        mag = (dot < 0) ? -dot : dot;
        mag = mag >> 14;
        return (mag > 65535) ? 16'hFFFF : mag[15:0];
    endfunction

    function logic [15:0] point_gap(logic signed [23:0] px, logic signed [23:0] py,
                                    logic signed [23:0] pz);
        longint s;
        longint mag;
        s = longint'(obs_n[0]) * longint'(px) + longint'(obs_n[1]) * longint'(py)
          + longint'(obs_n[2]) * longint'(pz) + longint'(obs_d) * 16384;
        mag = (s < 0) ? -s : s;
        mag = mag >> 14;
        return (mag > longint'(NEAR_CAP)) ? NEAR_CAP : mag[15:0];
    endfunction

    // association first, then most perpendicular, then most parallel
    function void decide_plane();
        logic live;
        live = cand_live && !cand_skip;
        cand_live = 1'b0;
        cand_skip = 1'b0;
        if (!live) return;
        if (cand_cos > assoc_thr && near_dist < best_dist) begin
            best_dist = near_dist;
            pick_idx[0] = cand_index;
            pick_seen[0] = 1'b1;
        end else if (cand_cos < best_vert) begin
            best_vert = cand_cos[14:0];
            pick_idx[1] = cand_index;
            pick_seen[1] = 1'b1;
        end else if (cand_cos > best_par) begin
            best_par = (cand_cos > 16'd32767) ? 15'h7FFF : cand_cos[14:0];
            pick_idx[2] = cand_index;
            pick_seen[2] = 1'b1;
        end
    endfunction

    function void note_item(pam_pkg::t_item it);
        t_assoc_result r;
        logic [15:0]   gap;
        case (it.mode)
            pam_pkg::MODE_OBS: begin
                if (it.first) frame_matches = '0;
                obs_n[0] = to_q14(it.vec_x);
                obs_n[1] = to_q14(it.vec_y);
                obs_n[2] = to_q14(it.vec_z);
                obs_d = it.offset;
                best_dist = dist_thr;
                best_vert = vert_thr;
                best_par = par_thr;
                foreach (pick_idx[k]) pick_idx[k] = '0;
                pick_seen = '0;
                cand_live = 1'b0;
                cand_skip = 1'b0;
                cand_cos = '0;
                cand_index = '0;
                near_dist = NEAR_CAP;
            end
            pam_pkg::MODE_HDR: begin
                decide_plane();
                cand_cos = normal_cos(it.vec_x, it.vec_y, it.vec_z);
                cand_index = it.index;
                cand_live = 1'b1;
                cand_skip = it.bad || (int'(it.index) >= pam_pkg::MAP_PLANES);
                near_dist = NEAR_CAP;
            end
            pam_pkg::MODE_PT: begin
                if (cand_live && !cand_skip) begin
                    gap = point_gap(it.vec_x, it.vec_y, it.vec_z);
                    if (gap < near_dist) near_dist = gap;
                end
            end
            pam_pkg::MODE_END: begin
                decide_plane();
                if (pick_seen[0] && frame_matches < MATCH_CAP) frame_matches++;
                r.matched = pick_seen[0];
                r.match_index = pick_seen[0] ? pick_idx[0] : '0;
                r.vertical_found = pick_seen[1];
                r.vertical_index = pick_seen[1] ? pick_idx[1] : '0;
                r.parallel_found = pick_seen[2];
                r.parallel_index = pick_seen[2] ? pick_idx[2] : '0;
                r.match_count = frame_matches;
                expected_picks.push_back(r);
                n_match += pick_seen[0];
                n_vert += pick_seen[1];
                n_par += pick_seen[2];
                pick_seen = '0;
                near_dist = NEAR_CAP;
            end
        endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_assoc_result got);
        t_assoc_result want;
        results_seen++;
        if (expected_picks.size() == 0) begin
            $error("result transfer with no end item waiting");
            errors++;
            return;
        end
        want = expected_picks.pop_front();
        compare_field("matched", want.matched, got.matched);
        compare_field("match_index", want.match_index, got.match_index);
        compare_field("vertical_found", want.vertical_found, got.vertical_found);
        compare_field("vertical_index", want.vertical_index, got.vertical_index);
        compare_field("parallel_found", want.parallel_found, got.parallel_found);
        compare_field("parallel_index", want.parallel_index, got.parallel_index);
        compare_field("match_count", want.match_count, got.match_count);
    endfunction

    function int outstanding();
        return expected_picks.size();
    endfunction
endclass

module tb_plane_association_matcher;

    localparam int LAT_SLACK = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pam_in_if  in_ch ();
    pam_out_if out_ch ();

    match_scoreboard sb = new();

    int items_sent = 0;
    int settings_used = 0;
    int rx_hold = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    plane_association_matcher #(
        .FRAME_PLANES(MATCH_CAP)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    // fields that the mode ignores get random values
    task automatic send_vec(logic [1:0] mode, logic first, int x, int y, int z, int ofs,
                            int idx, logic bad);
        pam_pkg::t_item it;
        int             gap;
        it.mode = mode;
        it.first = (mode == pam_pkg::MODE_OBS) ? first : 1'($urandom);
        it.vec_x = (mode == pam_pkg::MODE_END) ? 24'($urandom) : 24'(x);
        it.vec_y = (mode == pam_pkg::MODE_END) ? 24'($urandom) : 24'(y);
        it.vec_z = (mode == pam_pkg::MODE_END) ? 24'($urandom) : 24'(z);
        it.offset = (mode == pam_pkg::MODE_OBS) ? 24'(ofs) : 24'($urandom);
        it.index = (mode == pam_pkg::MODE_HDR) ? 10'(idx) : 10'($urandom);
        it.bad = (mode == pam_pkg::MODE_HDR) ? bad : 1'($urandom);
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.mode = it.mode;
        in_ch.first_of_frame = it.first;
        in_ch.vec_x = it.vec_x;
        in_ch.vec_y = it.vec_y;
        in_ch.vec_z = it.vec_z;
        in_ch.plane_offset = it.offset;
        in_ch.map_index = it.index;
        in_ch.map_bad = it.bad;
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apply_setting(int dist_lim, int assoc, int vert, int par);
        drain();
        repeat (LAT_SLACK) @(posedge i_clk);
        write_reg(pam_pkg::REG_DIST, dist_lim);
        write_reg(pam_pkg::REG_ASSOC, assoc);
        write_reg(pam_pkg::REG_VERT, vert);
        write_reg(pam_pkg::REG_PAR, par);
        settings_used++;
    endtask

    // observed plane near one axis, map planes aligned, perpendicular, oblique or wild,
    // points placed close to the observed plane
    task automatic send_frame(int max_maps, int max_pts, int first_pct);
        int   axis;
        int   other;
        int   sgn;
        int   d;
        int   n_maps;
        int   n_pts;
        int   kind;
        int   pick;
        int   n [3];
        int   m [3];
        int   p [3];
        logic first;
        axis = $urandom_range(2);
        sgn = $urandom_range(1) ? 1 : -1;
        d = spread(25600);
        foreach (n[k]) n[k] = spread(40);
        n[axis] = sgn * 16384 + spread(32);
        first = ($urandom_range(99) < first_pct);
        if ($urandom_range(15) == 0) begin
            send_vec(pam_pkg::MODE_OBS, first, $urandom, $urandom, $urandom, $urandom,
                     0, 0);
        end else begin
            send_vec(pam_pkg::MODE_OBS, first, n[0], n[1], n[2], d, 0, 0);
        end
        if ($urandom_range(7) == 0) begin
            send_vec(pam_pkg::MODE_PT, 0, $urandom, $urandom, $urandom, 0, 0, 0);
        end
        n_maps = $urandom_range(max_maps);
        for (int i = 0; i < n_maps; i++) begin
            kind = $urandom_range(9);
            other = (axis + 1 + $urandom_range(1)) % 3;
            foreach (m[k]) m[k] = spread(300);
            pick = $urandom_range(1) ? 16384 : -16384;
            case (kind)
                4, 5: begin
                    m[other] = pick + spread(300);
                    m[axis] = spread(600);
                end
                6, 7: begin
                    m[axis] = (pick > 0 ? 1 : -1) * int'($urandom_range(16384, 13000));
                    m[other] = spread(9000);
                end
                8: begin
                    foreach (m[k]) m[k] = $urandom;
                end
                default: begin
                    m[axis] = pick + spread(300);
                end
            endcase
            send_vec(pam_pkg::MODE_HDR, 0, m[0], m[1], m[2], 0, $urandom_range(1023),
                     kind == 9);
            n_pts = $urandom_range(max_pts);
            for (int j = 0; j < n_pts; j++) begin
                foreach (p[k]) p[k] = spread(2000);
                pick = $urandom_range(99);
                p[axis] = -sgn * d + ((pick < 70) ? spread(16) : spread(500));
                if (pick >= 95) begin
                    foreach (p[k]) p[k] = $urandom;
                end
                send_vec(pam_pkg::MODE_PT, 0, p[0], p[1], p[2], 0, 0, 0);
            end
        end
        pick = $urandom_range(19);
        if (pick < 19) send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
        if (pick == 18) send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic run_frames(int count, int max_maps, int max_pts, int first_pct);
        int start;
        start = items_sent;
        while (items_sent - start < count) send_frame(max_maps, max_pts, first_pct);
    endtask

    initial begin : receiver
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                out_ch.ready = 1'b0;
                rx_hold--;
            end else if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else begin
                out_ch.ready = 1'b1;
                if (!rx_steady) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_assoc_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.matched = out_ch.matched;
            got.match_index = out_ch.match_index;
            got.vertical_found = out_ch.vertical_found;
            got.vertical_index = out_ch.vertical_index;
            got.parallel_found = out_ch.parallel_found;
            got.parallel_index = out_ch.parallel_index;
            got.match_count = out_ch.match_count;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = pam_pkg::MODE_OBS;
        in_ch.first_of_frame = 1'b0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        in_ch.plane_offset = '0;
        in_ch.map_index = '0;
        in_ch.map_bad = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // stray point, match, bad plane, vertical and parallel picks, repeated end
        send_vec(pam_pkg::MODE_OBS, 1, 16384, 0, 0, -256, 0, 0);
        send_vec(pam_pkg::MODE_PT, 0, 5, 5, 5, 0, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 16384, 0, 0, 0, 5, 0);
        send_vec(pam_pkg::MODE_PT, 0, 256, 1000, -1000, 0, 0, 0);
        send_vec(pam_pkg::MODE_PT, 0, 300, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 16384, 0, 0, 0, 1023, 1);
        send_vec(pam_pkg::MODE_PT, 0, 256, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 0, 16384, 0, 0, 7, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 16000, 3000, 0, 0, 9, 0);
        send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
        // saturated normals, cosine and distance, parallel pick above range
        send_vec(pam_pkg::MODE_OBS, 0, 8388607, 8388607, -8388608, 8388607, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 8388607, 8388607, -8388608, 0, 3, 0);
        send_vec(pam_pkg::MODE_PT, 0, -8388608, 8388607, -8388608, 0, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, -8388608, -8388608, 8388607, 0, 0, 0);
        send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
        // pending plane dropped by a new observed plane, count cleared
        send_vec(pam_pkg::MODE_OBS, 0, -16384, 0, 0, -8388608, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, -16384, 0, 0, 0, 2, 0);
        send_vec(pam_pkg::MODE_PT, 0, -8388608, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_OBS, 1, 0, 0, 16384, 0, 0, 0);
        send_vec(pam_pkg::MODE_HDR, 0, 0, 0, -16384, 0, 1022, 0);
        send_vec(pam_pkg::MODE_PT, 0, 0, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_OBS, 1, 0, 16384, 0, 0, 0, 0);
        send_vec(pam_pkg::MODE_END, 0, 0, 0, 0, 0, 0, 0);

        apply_setting(20, 14090, 1311, 14746);
        run_frames(180, 6, 5, 20);

        // loose limits: nearly every plane matches, count runs into saturation
        apply_setting(65535, 0, 16384, 0);
        @(posedge i_clk);
        rx_hold = 300;
        tx_steady = 1'b1;
        repeat (40) send_frame(1, 0, 0);
        tx_steady = 1'b0;
        drain();
        run_frames(200, 1, 1, 0);

        // tight limits: only over-range cosines pick a parallel plane
        apply_setting(0, 16384, 0, 16384);
        run_frames(160, 5, 4, 15);

        apply_setting($urandom_range(200), $urandom_range(16384, 12000),
                      $urandom_range(4000), $urandom_range(16384, 12000));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_frames(160, 6, 5, 15);
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        apply_setting($urandom_range(65535), $urandom_range(16384), $urandom_range(16384),
                      $urandom_range(16384));
        run_frames(180, 6, 5, 10);

        drain();
        repeat (20) @(posedge i_clk);
        $display("ran %0d item transfers and %0d result transfers over %0d register settings",
                 items_sent, sb.results_seen, settings_used + 1);
        $display("expected picks: %0d matched, %0d vertical, %0d parallel",
                 sb.n_match, sb.n_vert, sb.n_par);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
